// ----- rtl/core/qapm_pkg.sv -----
`timescale 1ns / 1ps
// Package for the quad attitude PD controller and X-frame motor mixer.
// Holds the word structs, op and register codes, sequencer states and constants.
// No dependencies.
package qapm_pkg;

  localparam int ANGLE_FRAC_BITS = 7;
  localparam int DERIV_FRAC      = 16;
  localparam int PULSE_LO        = 1000;
  localparam int STAB_SPAN       = 15;
  localparam int MOTOR_MAX       = 4095;
  localparam int RECIP_MUL       = 2147484;
  localparam int RECIP_SHIFT     = 31;
  localparam int ERR_W           = 24;
  localparam int DIV_NUM_W       = 44;
  localparam int DIV_DEN_W       = 20;
  localparam int DIV_STEP_BITS   = 4;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 16;
  localparam logic [7:0] MANUAL_LIMIT_RST = 8'd100;

  typedef enum logic [1:0] {
    OP_STAB   = 2'd0,
    OP_MANUAL = 2'd1,
    OP_KILL   = 2'd2
  } qapm_op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROLL_P       = 3'd0,
    CFG_ROLL_D       = 3'd1,
    CFG_PITCH_P      = 3'd2,
    CFG_PITCH_D      = 3'd3,
    CFG_MANUAL_LIMIT = 3'd4
  } qapm_cfg_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MAP_MUL,
    S_MAP_ABS,
    S_MAP_REC,
    S_MAP_END,
    S_DIV_GO,
    S_DIV_WAIT,
    S_D_LO,
    S_D_HI,
    S_ACC,
    S_SCALE,
    S_MIX,
    S_OUT
  } qapm_state_e;

  typedef struct packed {
    logic [1:0]         op;
    logic [11:0]        stick_roll;
    logic [11:0]        stick_pitch;
    logic [11:0]        stick_yaw;
    logic [11:0]        stick_throttle;
    logic signed [15:0] measured_roll;
    logic signed [15:0] measured_pitch;
    logic [19:0]        elapsed_us;
  } qapm_in_t;

  typedef struct packed {
    logic [11:0] motor_front_a;
    logic [11:0] motor_front_b;
    logic [11:0] motor_rear_a;
    logic [11:0] motor_rear_b;
    logic        clipped;
  } qapm_out_t;

endpackage

// ----- rtl/core/quad_attitude_pd_mixer.sv -----
`timescale 1ns / 1ps
// Quad attitude PD controller with X-frame mixer: top level, sequencer and datapath.
// Depends on qapm_pkg and qapm_div.
//
//   channel | handshake               | word
//   --------+-------------------------+-----------
//   cfg     | cfg_we_i                | cfg_idx_i, cfg_data_i
//   in      | in_valid_i / in_stall_o | in_word_i  (qapm_in_t)
//   out     | out_valid_o/out_stall_i | out_word_o (qapm_out_t)
//
// Cost is set by one shared 25x25 multiplier and one 4-bit-per-cycle divider
// (11 steps per axis). One word at a time; a new word is taken while the
// result waits in the output register. Reset clears state and loads register defaults.
module quad_attitude_pd_mixer
  import qapm_pkg::*;
#(
  parameter int AngleFracBits = ANGLE_FRAC_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  qapm_in_t              in_word_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output qapm_out_t             out_word_o
);

  localparam int MulW    = 25;
  localparam int ProdW   = 2 * MulW;
  localparam int AccW    = 58;
  localparam int TgtW    = AccW - DERIV_FRAC;
  localparam int DerivW  = 42;
  localparam int LoW     = 24;
  localparam int SumW    = TgtW + 3;
  localparam int MapW    = 12;
  localparam int QW      = 11;
  localparam int MagW    = 21;
  localparam int ErrRawW = 26;
  localparam int DiffW   = ERR_W + 1;
  localparam int ScaleSh = AngleFracBits + DERIV_FRAC;
  localparam logic signed [ErrRawW-1:0] ErrHi = ErrRawW'(2 ** (ERR_W - 1) - 1);
  localparam logic signed [ErrRawW-1:0] ErrLo = -ErrHi - ErrRawW'(1);
  localparam logic signed [AccW-1:0] ScaleBias = AccW'((AccW'(1) << ScaleSh) - AccW'(1));

  qapm_state_e state_q, state_d;

  logic [1:0] ax_q, ax_d, mot_q, mot_d;
  logic       out_valid_q, out_valid_d;
  logic       accept, out_load;

  logic signed [15:0] roll_p_q, roll_d_q, pitch_p_q, pitch_d_q;
  logic [7:0]         lim_q;

  qapm_in_t  inw_q, inw_d;
  qapm_out_t out_q, out_d;

  logic [11:0]              c_q, c_d;
  logic signed [TgtW-1:0]   r_q, r_d, p_q, p_d;
  logic signed [15:0]       yaw_q, yaw_d;
  logic signed [ERR_W-1:0]  prev_roll_q, prev_roll_d, prev_pitch_q, prev_pitch_d;
  logic signed [ERR_W-1:0]  err_q, err_d;
  logic signed [ProdW-1:0]  mul_q, mul_d, mul_abs;
  logic [MagW-1:0]          mag_q, mag_d;
  logic                     neg_q, neg_d, clip_q, clip_d;
  logic signed [DerivW-1:0] deriv_q, deriv_d, quo_s;
  logic signed [AccW-1:0]   acc_q, acc_d, acc_bias, tgt_full;
  logic [11:0]              motor_q [4];

  logic signed [MulW-1:0]    mul_a, mul_b;
  logic                      is_stab;
  logic [11:0]               stick_sel;
  logic signed [15:0]        meas_sel, p_sel, d_sel;
  logic signed [ERR_W-1:0]   prev_sel;
  logic signed [12:0]        x_off;
  logic [9:0]                span;
  logic signed [MapW-1:0]    lo, q_s, map_val;
  logic signed [ErrRawW-1:0] err_raw;
  logic signed [DiffW-1:0]   diff;
  logic [DiffW-1:0]          diff_mag;
  logic [DIV_NUM_W-1:0]      div_num, div_quo;
  logic [DIV_DEN_W-1:0]      dt;
  logic                      div_start, div_done;
  logic signed [SumW-1:0]    sum;
  logic [11:0]               sat_val;
  logic                      sat_clip;

  assign accept   = (state_q == S_IDLE) && in_valid_i;
  assign out_load = (state_q == S_OUT) && (!out_valid_q || !out_stall_i);
  assign is_stab  = (inw_q.op == OP_STAB);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      roll_p_q  <= '0;
      roll_d_q  <= '0;
      pitch_p_q <= '0;
      pitch_d_q <= '0;
      lim_q     <= MANUAL_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (qapm_cfg_e'(cfg_idx_i))
        CFG_ROLL_P:       roll_p_q  <= cfg_data_i;
        CFG_ROLL_D:       roll_d_q  <= cfg_data_i;
        CFG_PITCH_P:      pitch_p_q <= cfg_data_i;
        CFG_PITCH_D:      pitch_d_q <= cfg_data_i;
        CFG_MANUAL_LIMIT: lim_q     <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Per-axis operand selection
  always_comb begin
    case (ax_q)
      2'd0: begin
        stick_sel = inw_q.stick_roll;
        meas_sel  = inw_q.measured_roll;
        prev_sel  = prev_roll_q;
        p_sel     = roll_p_q;
        d_sel     = roll_d_q;
      end
      2'd1: begin
        stick_sel = inw_q.stick_pitch;
        meas_sel  = inw_q.measured_pitch;
        prev_sel  = prev_pitch_q;
        p_sel     = pitch_p_q;
        d_sel     = pitch_d_q;
      end
      default: begin
        stick_sel = inw_q.stick_yaw;
        meas_sel  = inw_q.measured_pitch;
        prev_sel  = prev_pitch_q;
        p_sel     = pitch_p_q;
        d_sel     = pitch_d_q;
      end
    endcase
  end

  always_comb begin
    x_off    = $signed({1'b0, stick_sel}) - $signed(13'(PULSE_LO));
    span     = is_stab ? 10'(2 * STAB_SPAN) : {1'b0, lim_q, 1'b0};
    lo       = is_stab ? -$signed(MapW'(STAB_SPAN)) : -$signed({4'b0, lim_q});
    mul_abs  = mul_q[ProdW-1] ? -mul_q : mul_q;
    q_s      = $signed({1'b0, mul_q[RECIP_SHIFT +: QW]});
    map_val  = (neg_q ? -q_s : q_s) + lo;
    err_raw  = (ErrRawW'(map_val) <<< AngleFracBits) - ErrRawW'(meas_sel);
    diff     = DiffW'(err_q) - DiffW'(prev_sel);
    diff_mag = diff[DiffW-1] ? DiffW'(-diff) : DiffW'(diff);
    div_num  = DIV_NUM_W'({diff_mag, {DERIV_FRAC{1'b0}}});
    dt       = (inw_q.elapsed_us == '0) ? DIV_DEN_W'(1) : inw_q.elapsed_us;
    quo_s    = $signed(div_quo[DerivW-1:0]);
    acc_bias = acc_q + (acc_q[AccW-1] ? ScaleBias : AccW'(0));
    tgt_full = acc_bias >>> ScaleSh;
  end

  // Shared multiplier operands
  always_comb begin
    case (state_q)
      S_MAP_MUL: begin
        mul_a = MulW'(x_off);
        mul_b = MulW'($signed({1'b0, span}));
      end
      S_MAP_REC: begin
        mul_a = $signed(MulW'(mag_q));
        mul_b = $signed(MulW'(RECIP_MUL));
      end
      S_D_LO: begin
        mul_a = MulW'(d_sel);
        mul_b = $signed({1'b0, deriv_q[LoW-1:0]});
      end
      S_D_HI: begin
        mul_a = MulW'(d_sel);
        mul_b = MulW'($signed(deriv_q[DerivW-1:LoW]));
      end
      default: begin
        mul_a = MulW'(p_sel);
        mul_b = MulW'(err_q);
      end
    endcase
    mul_d = mul_a * mul_b;
  end

  // Mixer: one motor per cycle
  always_comb begin
    sum = $signed(SumW'(c_q))
        + (mot_q[0] ? -SumW'(r_q) : SumW'(r_q))
        + (mot_q[1] ? -SumW'(p_q) : SumW'(p_q))
        + ((mot_q[0] ^ mot_q[1]) ? -SumW'(yaw_q) : SumW'(yaw_q));
    if (sum < 0) begin
      sat_val  = '0;
      sat_clip = 1'b1;
    end else if (sum > $signed(SumW'(MOTOR_MAX))) begin
      sat_val  = 12'(MOTOR_MAX);
      sat_clip = 1'b1;
    end else begin
      sat_val  = sum[11:0];
      sat_clip = 1'b0;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (in_word_i.op == OP_STAB || in_word_i.op == OP_MANUAL) begin
            state_d = S_MAP_MUL;
          end else begin
            state_d = S_MIX;
          end
        end
      end
      S_MAP_MUL: state_d = S_MAP_ABS;
      S_MAP_ABS: state_d = S_MAP_REC;
      S_MAP_REC: state_d = S_MAP_END;
      S_MAP_END: begin
        if (is_stab) begin
          state_d = S_DIV_GO;
        end else if (ax_q == 2'd2) begin
          state_d = S_MIX;
        end else begin
          state_d = S_MAP_MUL;
        end
      end
      S_DIV_GO:   state_d = S_DIV_WAIT;
      S_DIV_WAIT: if (div_done) state_d = S_D_LO;
      S_D_LO:     state_d = S_D_HI;
      S_D_HI:     state_d = S_ACC;
      S_ACC:      state_d = S_SCALE;
      S_SCALE:    state_d = (ax_q == 2'd1) ? S_MIX : S_MAP_MUL;
      S_MIX:      if (mot_q == 2'd3) state_d = S_OUT;
      S_OUT:      if (out_load) state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  always_comb begin
    ax_d         = ax_q;
    mot_d        = mot_q;
    inw_d        = inw_q;
    c_d          = c_q;
    r_d          = r_q;
    p_d          = p_q;
    yaw_d        = yaw_q;
    prev_roll_d  = prev_roll_q;
    prev_pitch_d = prev_pitch_q;
    err_d        = err_q;
    mag_d        = mag_q;
    neg_d        = neg_q;
    deriv_d      = deriv_q;
    acc_d        = acc_q;
    clip_d       = clip_q;
    div_start    = 1'b0;
    out_valid_d  = out_valid_q && out_stall_i;
    out_d        = out_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          inw_d  = in_word_i;
          ax_d   = 2'd0;
          mot_d  = 2'd0;
          clip_d = 1'b0;
          r_d    = '0;
          p_d    = '0;
          if (in_word_i.op == OP_STAB || in_word_i.op == OP_MANUAL) begin
            c_d = in_word_i.stick_throttle;
          end else begin
            c_d   = '0;
            yaw_d = '0;
          end
        end
      end
      S_MAP_ABS: begin
        neg_d = mul_q[ProdW-1];
        mag_d = mul_abs[MagW-1:0];
      end
      S_MAP_END: begin
        if (is_stab) begin
          if (err_raw > ErrHi) begin
            err_d = ErrHi[ERR_W-1:0];
          end else if (err_raw < ErrLo) begin
            err_d = ErrLo[ERR_W-1:0];
          end else begin
            err_d = err_raw[ERR_W-1:0];
          end
        end else begin
          case (ax_q)
            2'd0:    r_d   = TgtW'(map_val);
            2'd1:    p_d   = TgtW'(map_val);
            default: yaw_d = 16'(map_val);
          endcase
          ax_d = ax_q + 2'd1;
        end
      end
      S_DIV_GO: begin
        div_start = 1'b1;
        neg_d     = diff[DiffW-1];
        if (ax_q == 2'd0) begin
          prev_roll_d = err_q;
        end else begin
          prev_pitch_d = err_q;
        end
      end
      S_DIV_WAIT: begin
        if (div_done) begin
          deriv_d = neg_q ? -quo_s : quo_s;
          acc_d   = AccW'(mul_q) <<< DERIV_FRAC;
        end
      end
      S_D_HI: acc_d = acc_q - AccW'(mul_q);
      S_ACC:  acc_d = acc_q - (AccW'(mul_q) <<< LoW);
      S_SCALE: begin
        if (ax_q == 2'd0) begin
          r_d = tgt_full[TgtW-1:0];
        end else begin
          p_d = tgt_full[TgtW-1:0];
        end
        ax_d = ax_q + 2'd1;
      end
      S_MIX: begin
        mot_d  = mot_q + 2'd1;
        clip_d = clip_q | sat_clip;
      end
      S_OUT: begin
        if (out_load) begin
          out_valid_d         = 1'b1;
          out_d.motor_front_a = motor_q[0];
          out_d.motor_front_b = motor_q[1];
          out_d.motor_rear_a  = motor_q[2];
          out_d.motor_rear_b  = motor_q[3];
          out_d.clipped       = clip_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      ax_q         <= '0;
      mot_q        <= '0;
      out_valid_q  <= 1'b0;
      yaw_q        <= '0;
      prev_roll_q  <= '0;
      prev_pitch_q <= '0;
    end else begin
      state_q      <= state_d;
      ax_q         <= ax_d;
      mot_q        <= mot_d;
      out_valid_q  <= out_valid_d;
      yaw_q        <= yaw_d;
      prev_roll_q  <= prev_roll_d;
      prev_pitch_q <= prev_pitch_d;
    end
  end

  always_ff @(posedge clk_i) begin
    inw_q   <= inw_d;
    c_q     <= c_d;
    r_q     <= r_d;
    p_q     <= p_d;
    err_q   <= err_d;
    mul_q   <= mul_d;
    mag_q   <= mag_d;
    neg_q   <= neg_d;
    deriv_q <= deriv_d;
    acc_q   <= acc_d;
    clip_q  <= clip_d;
    out_q   <= out_d;
    if (state_q == S_MIX) begin
      motor_q[mot_q] <= sat_val;
    end
  end

  qapm_div #(
    .NumW     (DIV_NUM_W),
    .DenW     (DIV_DEN_W),
    .StepBits (DIV_STEP_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (dt),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o) else $error("not busy after accept");
  a_clip_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.clipped) |->
      (out_word_o.motor_front_a == 12'd0 || out_word_o.motor_front_a == 12'd4095 ||
       out_word_o.motor_front_b == 12'd0 || out_word_o.motor_front_b == 12'd4095 ||
       out_word_o.motor_rear_a == 12'd0 || out_word_o.motor_rear_a == 12'd4095 ||
       out_word_o.motor_rear_b == 12'd0 || out_word_o.motor_rear_b == 12'd4095))
    else $error("clip flag without a saturated motor");
  a_div_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIV_WAIT) else $error("divider done outside wait");
  a_out_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == S_OUT) else $error("result without sequencer");
`endif

endmodule

// ----- rtl/core/qapm_div.sv -----
`timescale 1ns / 1ps
// Iterative unsigned restoring divider, StepBits quotient bits per cycle.
// Depends on qapm_pkg for default widths.
module qapm_div
  import qapm_pkg::*;
#(
  parameter int NumW     = DIV_NUM_W,
  parameter int DenW     = DIV_DEN_W,
  parameter int StepBits = DIV_STEP_BITS
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic            done_o,
  output logic [NumW-1:0] quo_o
);

  localparam int Steps = NumW / StepBits;
  localparam int CntW  = $clog2(Steps + 1);

  logic [CntW-1:0] cnt_q;
  logic            done_q;
  logic [NumW-1:0] work_q, work_n;
  logic [DenW-1:0] rem_q, rem_n, den_q;
  logic [DenW:0]   trial;

  always_comb begin
    rem_n  = rem_q;
    work_n = work_q;
    trial  = '0;
    for (int i = 0; i < StepBits; i++) begin
      trial  = {rem_n, work_n[NumW-1]};
      work_n = {work_n[NumW-2:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        trial     = trial - {1'b0, den_q};
        work_n[0] = 1'b1;
      end
      rem_n = trial[DenW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= CntW'(Steps);
      done_q <= 1'b0;
    end else if (cnt_q != '0) begin
      cnt_q  <= cnt_q - CntW'(1);
      done_q <= (cnt_q == CntW'(1));
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      work_q <= num_i;
      rem_q  <= '0;
      den_q  <= den_i;
    end else if (cnt_q != '0) begin
      work_q <= work_n;
      rem_q  <= rem_n;
    end
  end

  assign done_o = done_q;
  assign quo_o  = work_q;

`ifndef SYNTH
  a_start_no_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> !done_o) else $error("divider done right after start");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("divider done longer than one cycle");
  a_start_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> cnt_q == CntW'(Steps)) else $error("divider count not loaded");
`endif

endmodule

// ----- tb/quad_attitude_pd_mixer_test.sv -----
`timescale 1ns / 1ps
// Self-checking bench for quad_attitude_pd_mixer: random and directed words through the
// valid/stall channels, checked against an in-bench PD controller and X-mixer predictor.
// Depends on qapm_pkg and the RTL of quad_attitude_pd_mixer.
module quad_attitude_pd_mixer_test;
  import qapm_pkg::*;

  localparam int          PULSE_SPAN     = 1000;
  localparam int          WATCHDOG_LIMIT = 4000;
  localparam int          HOLD_CYCLES    = 400;
  localparam int          CHUNK_WORDS    = 95;
  localparam int          PHASES         = 8;
  localparam logic [1:0]  OP_UNUSED      = 2'd3;
  localparam longint      ERR_HI         = (longint'(1) << (ERR_W - 1)) - 1;
  localparam longint      ERR_LO         = -(longint'(1) << (ERR_W - 1));

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  qapm_in_t              in_word_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  qapm_out_t             out_word_o;

  qapm_in_t  pending_words[$];
  qapm_out_t expected_motors[$];
  qapm_out_t want;

  longint gain_q [4];
  longint manual_span;
  longint roll_err_last;
  longint pitch_err_last;
  longint yaw_hold;

  bit word_taken;
  bit steady;
  bit hold_req;
  int send_wait;
  int stall_left;
  int hold_left;
  int quiet_cycles;
  int fails;

  quad_attitude_pd_mixer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic longint map_pulse(logic [11:0] stick, longint lo, longint hi);
    return (longint'(stick) - PULSE_LO) * (hi - lo) / PULSE_SPAN + lo;
  endfunction

  function automatic longint axis_command(longint tgt_deg, longint meas, inout longint err_last,
                                          input longint kp, longint kd, longint dt);
    longint err;
    longint rate;
    longint acc;
    err = tgt_deg * (longint'(1) << ANGLE_FRAC_BITS) - meas;
    if (err > ERR_HI) err = ERR_HI;
    if (err < ERR_LO) err = ERR_LO;
    rate = (err - err_last) * (longint'(1) << DERIV_FRAC) / dt;
    acc = kp * err * (longint'(1) << DERIV_FRAC) - kd * rate;
    err_last = err;
    return acc / (longint'(1) << (ANGLE_FRAC_BITS + DERIV_FRAC));
  endfunction

  function automatic logic [11:0] sat_motor(longint v, inout bit clip);
    if (v < 0) begin
      clip = 1'b1;
      return '0;
    end
    if (v > MOTOR_MAX) begin
      clip = 1'b1;
      return 12'(MOTOR_MAX);
    end
    return 12'(v);
  endfunction

  function automatic qapm_out_t predict_motors(qapm_in_t w);
    longint    roll_cmd;
    longint    pitch_cmd;
    longint    collective;
    longint    dt;
    bit        clip;
    qapm_out_t res;
    roll_cmd   = 0;
    pitch_cmd  = 0;
    collective = 0;
    clip       = 1'b0;
    case (w.op)
      OP_STAB: begin
        dt = (w.elapsed_us == '0) ? 1 : longint'(w.elapsed_us);
        roll_cmd = axis_command(map_pulse(w.stick_roll, -STAB_SPAN, STAB_SPAN),
                                longint'($signed(w.measured_roll)), roll_err_last,
                                gain_q[CFG_ROLL_P], gain_q[CFG_ROLL_D], dt);
        pitch_cmd = axis_command(map_pulse(w.stick_pitch, -STAB_SPAN, STAB_SPAN),
                                 longint'($signed(w.measured_pitch)), pitch_err_last,
                                 gain_q[CFG_PITCH_P], gain_q[CFG_PITCH_D], dt);
        collective = longint'(w.stick_throttle);
      end
      OP_MANUAL: begin
        roll_cmd   = map_pulse(w.stick_roll, -manual_span, manual_span);
        pitch_cmd  = map_pulse(w.stick_pitch, -manual_span, manual_span);
        yaw_hold   = map_pulse(w.stick_yaw, -manual_span, manual_span);
        collective = longint'(w.stick_throttle);
      end
      default: begin
        yaw_hold = 0;
      end
    endcase
    res.motor_front_a = sat_motor(collective + roll_cmd + pitch_cmd + yaw_hold, clip);
    res.motor_front_b = sat_motor(collective - roll_cmd + pitch_cmd - yaw_hold, clip);
    res.motor_rear_a  = sat_motor(collective + roll_cmd - pitch_cmd - yaw_hold, clip);
    res.motor_rear_b  = sat_motor(collective - roll_cmd - pitch_cmd + yaw_hold, clip);
    res.clipped       = clip;
    return res;
  endfunction

  function automatic int idle_len();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(40, 120);
  endfunction

  function automatic logic [11:0] rand_pulse();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return 12'($urandom_range(900, 2100));
    if (r < 92) return 12'($urandom_range(0, 3000));
    return 12'($urandom);
  endfunction

  function automatic logic [15:0] rand_angle();
    if ($urandom_range(0, 99) < 85) return 16'($signed($urandom_range(0, 46080)) - 23040);
    return 16'($urandom);
  endfunction

  function automatic logic [19:0] rand_elapsed();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 20'($urandom_range(200, 20000));
    if (r < 80) return 20'($urandom_range(0, 3));
    if (r < 90) return 20'($urandom_range(1, 1000000));
    return 20'($urandom);
  endfunction

  function automatic logic [15:0] rand_gain();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 16'($signed($urandom_range(0, 128)) - 64);
    if (r < 80) return 16'($signed($urandom_range(0, 8000)) - 4000);
    return 16'($urandom);
  endfunction

  function automatic qapm_in_t rand_word();
    qapm_in_t w;
    int       r;
    r = $urandom_range(0, 99);
    if (r < 60) w.op = OP_STAB;
    else if (r < 85) w.op = OP_MANUAL;
    else if (r < 95) w.op = OP_KILL;
    else w.op = OP_UNUSED;
    w.stick_roll     = rand_pulse();
    w.stick_pitch    = rand_pulse();
    w.stick_yaw      = rand_pulse();
    w.stick_throttle = rand_pulse();
    w.measured_roll  = rand_angle();
    w.measured_pitch = rand_angle();
    w.elapsed_us     = rand_elapsed();
    return w;
  endfunction

  function automatic void push_word(logic [1:0] op, logic [11:0] sr, logic [11:0] sp,
                                    logic [11:0] sy, logic [11:0] st, logic [15:0] mr,
                                    logic [15:0] mp, logic [19:0] dt);
    qapm_in_t w;
    w.op             = op;
    w.stick_roll     = sr;
    w.stick_pitch    = sp;
    w.stick_yaw      = sy;
    w.stick_throttle = st;
    w.measured_roll  = mr;
    w.measured_pitch = mp;
    w.elapsed_us     = dt;
    pending_words.push_back(w);
  endfunction

  function automatic void check_field(string name, int unsigned exp_v, int unsigned got_v);
    if (exp_v != got_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
      fails++;
    end
  endfunction

  task automatic write_regs(logic [15:0] rp, logic [15:0] rd, logic [15:0] pp,
                            logic [15:0] pd, logic [7:0] lim);
    logic [15:0] vals [5];
    vals = '{rp, rd, pp, pd, {8'h00, lim}};
    for (int i = 0; i < 5; i++) begin
      @(negedge clk_i);
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= qapm_cfg_e'(i);
      cfg_data_i <= vals[i];
      if (qapm_cfg_e'(i) == CFG_MANUAL_LIMIT) manual_span = longint'(vals[i][7:0]);
      else gain_q[i] = longint'($signed(vals[i]));
    end
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(posedge clk_i);
    while (pending_words.size() != 0 || in_valid_i || expected_motors.size() != 0);
  endtask

  task automatic load_directed();
    push_word(OP_STAB, 12'd1500, 12'd1500, 12'd1500, 12'd1500, 16'sd0, 16'sd0, 20'd1000);
    push_word(OP_STAB, 12'd0, 12'd4095, 12'd0, 12'd1500, 16'sh7FFF, 16'sh8000, 20'd0);
    push_word(OP_STAB, 12'd4095, 12'd0, 12'd4095, 12'd1500, 16'sh8000, 16'sh7FFF, 20'd1);
    push_word(OP_STAB, 12'd1000, 12'd2000, 12'd1500, 12'd2000, -16'sd23040, 16'sd23040,
              20'hFFFFF);
    push_word(OP_STAB, 12'd2000, 12'd1000, 12'd1500, 12'd1000, 16'sd23040, -16'sd23040,
              20'd1000000);
    push_word(OP_MANUAL, 12'd0, 12'd4095, 12'd4095, 12'd4095, 16'sd0, 16'sd0, 20'd0);
    push_word(OP_MANUAL, 12'd4095, 12'd0, 12'd0, 12'd0, 16'sd0, 16'sd0, 20'd0);
    push_word(OP_MANUAL, 12'd1000, 12'd2000, 12'd1000, 12'd1500, 16'sd5, -16'sd5, 20'd7);
    push_word(OP_MANUAL, 12'd2000, 12'd1000, 12'd2000, 12'd3000, 16'sd0, 16'sd0, 20'd0);
    push_word(OP_STAB, 12'd1500, 12'd1500, 12'd0, 12'd3000, 16'sd100, -16'sd100, 20'd2500);
    push_word(OP_KILL, 12'd2000, 12'd2000, 12'd2000, 12'd2000, 16'sd0, 16'sd0, 20'd10);
    push_word(OP_STAB, 12'd1600, 12'd1400, 12'd1500, 12'd1200, 16'sd640, -16'sd640, 20'd500);
    push_word(OP_UNUSED, 12'd2000, 12'd1000, 12'd3000, 12'd2500, 16'sd1, 16'sd1, 20'd1);
    push_word(OP_MANUAL, 12'd1500, 12'd1500, 12'd1500, 12'd4095, 16'sd0, 16'sd0, 20'd0);
    push_word(OP_STAB, 12'd1500, 12'd1500, 12'd1500, 12'd0, 16'sd0, 16'sd0, 20'd1);
    push_word(OP_STAB, 12'hAAA, 12'h555, 12'h555, 12'hAAA, 16'sh5555, 16'shAAAA, 20'hAAAAA);
    push_word(OP_MANUAL, 12'h555, 12'hAAA, 12'hAAA, 12'h555, 16'shAAAA, 16'sh5555, 20'h55555);
  endtask

  task automatic program_phase(int ph);
    case (ph)
      1: write_regs(16'sd20, 16'sd3000, -16'sd12, -16'sd2500, 8'd37);
      2: write_regs(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 8'd0);
      3: write_regs(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 8'd255);
      default: write_regs(rand_gain(), rand_gain(), rand_gain(), rand_gain(),
                          8'($urandom_range(0, 255)));
    endcase
  endtask

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (word_taken || !in_valid_i) begin
        word_taken = 1'b0;
        if (send_wait > 0 || pending_words.size() == 0) begin
          if (send_wait > 0) send_wait--;
          in_valid_i <= 1'b0;
        end else begin
          in_word_i  <= pending_words.pop_front();
          in_valid_i <= 1'b1;
          send_wait  = idle_len();
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else begin
      out_stall_i <= 1'b0;
      stall_left = idle_len();
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        expected_motors.push_back(predict_motors(in_word_i));
        word_taken = 1'b1;
      end
      if (out_valid_o && !out_stall_i) begin
        if (expected_motors.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, out_word_o);
          fails++;
        end else begin
          want = expected_motors.pop_front();
          check_field("motor_front_a", want.motor_front_a, out_word_o.motor_front_a);
          check_field("motor_front_b", want.motor_front_b, out_word_o.motor_front_b);
          check_field("motor_rear_a", want.motor_rear_a, out_word_o.motor_rear_a);
          check_field("motor_rear_b", want.motor_rear_b, out_word_o.motor_rear_b);
          check_field("clipped", want.clipped, out_word_o.clipped);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    gain_q         = '{0, 0, 0, 0};
    manual_span    = longint'(MANUAL_LIMIT_RST);
    roll_err_last  = 0;
    pitch_err_last = 0;
    yaw_hold       = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph > 0) program_phase(ph);
      if (ph == 1) load_directed();
      if (ph == 3) begin
        steady   = 1'b1;
        hold_req = 1'b1;
      end
      repeat (CHUNK_WORDS) pending_words.push_back(rand_word());
      wait_drained();
      steady = ph[0];
      repeat (CHUNK_WORDS) pending_words.push_back(rand_word());
      wait_drained();
      steady = 1'b0;
    end
    repeat (60) @(posedge clk_i);
    if (expected_motors.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, expected_motors.size());
      fails++;
    end
    if (fails == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
